@@ hw/rtl/cpt_pkg.sv @@
// Shared types for the coprime pair test block.
package cpt_pkg;

  typedef struct packed {
    logic clear;
    logic step;
  } sub_ctl_t;

endpackage

@@ hw/rtl/cpt_sub.sv @@
// Bit-serial subtractor forming both differences of two operands, LSB first.
module cpt_sub #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  cpt_pkg::sub_ctl_t      ctl,
  input  logic                   a_bit,
  input  logic                   b_bit,
  output logic [VALUE_WIDTH-1:0] diff_ab,
  output logic [VALUE_WIDTH-1:0] diff_ba,
  output logic                   a_ge_b
);
  import cpt_pkg::*;

  logic borrow_ab;
  logic borrow_ba;
  logic bit_ab;
  logic bit_ba;
  logic borrow_ab_next;
  logic borrow_ba_next;

  always_comb begin
    bit_ab = a_bit ^ b_bit ^ borrow_ab;
    bit_ba = a_bit ^ b_bit ^ borrow_ba;
    borrow_ab_next = (~a_bit & b_bit) | (~(a_bit ^ b_bit) & borrow_ab);
    borrow_ba_next = (~b_bit & a_bit) | (~(a_bit ^ b_bit) & borrow_ba);
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      borrow_ab <= 1'b0;
      borrow_ba <= 1'b0;
    end else if (ctl.step) begin
      borrow_ab <= borrow_ab_next;
      borrow_ba <= borrow_ba_next;
      diff_ab   <= {bit_ab, diff_ab[VALUE_WIDTH-1:1]};
      diff_ba   <= {bit_ba, diff_ba[VALUE_WIDTH-1:1]};
    end
  end

  assign a_ge_b = ~borrow_ab;

endmodule

@@ hw/rtl/coprime_pair_test.sv @@
// Top level of the coprime pair test block.
// Reports whether two unsigned values share no divisor from 2 up to the smaller of them; a
// smaller value of zero or one always reports coprime. The test runs binary GCD one item at a
// time: a common factor of two ends it at once, single-bit halvings strip other factors of two,
// and each subtraction goes through a bit-serial subtractor. The time an item takes is set by
// the number of halvings and of passes through the serial subtractor.
// A finished result waits in the output register while the next transaction is accepted.
module coprime_pair_test #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] first_value,
  input  logic [VALUE_WIDTH-1:0] second_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   is_coprime
);
  import cpt_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH);
  localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_WIDTH - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_REDUCE = 3'd2;
  localparam logic [2:0] S_SUB    = 3'd3;
  localparam logic [2:0] S_APPLY  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]             state;
  logic [VALUE_WIDTH-1:0] a;
  logic [VALUE_WIDTH-1:0] b;
  logic [CW-1:0]          cnt;
  logic                   res;
  sub_ctl_t               sub_ctl;
  logic [VALUE_WIDTH-1:0] diff_ab;
  logic [VALUE_WIDTH-1:0] diff_ba;
  logic                   a_ge_b;
  logic                   a_small;
  logic                   b_small;
  logic                   a_zero;
  logic                   b_zero;

  assign a_small  = (a[VALUE_WIDTH-1:1] == '0);
  assign b_small  = (b[VALUE_WIDTH-1:1] == '0);
  assign a_zero   = a_small & ~a[0];
  assign b_zero   = b_small & ~b[0];
  assign in_ready = (state == S_IDLE);

  always_comb begin
    sub_ctl.clear = (state == S_REDUCE);
    sub_ctl.step  = (state == S_SUB);
  end

  cpt_sub #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_sub (
    .clk     (clk),
    .ctl     (sub_ctl),
    .a_bit   (a[0]),
    .b_bit   (b[0]),
    .diff_ab (diff_ab),
    .diff_ba (diff_ba),
    .a_ge_b  (a_ge_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            a     <= first_value;
            b     <= second_value;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (a_small || b_small) begin
            res   <= 1'b1;
            state <= S_FINISH;
          end else if (!a[0] && !b[0]) begin
            res   <= 1'b0;
            state <= S_FINISH;
          end else begin
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (a_zero) begin
            res   <= b_small & b[0];
            state <= S_FINISH;
          end else if (b_zero) begin
            res   <= a_small & a[0];
            state <= S_FINISH;
          end else if (!a[0]) begin
            a <= {1'b0, a[VALUE_WIDTH-1:1]};
          end else if (!b[0]) begin
            b <= {1'b0, b[VALUE_WIDTH-1:1]};
          end else begin
            cnt   <= '0;
            state <= S_SUB;
          end
        end
        S_SUB: begin
          a   <= {a[0], a[VALUE_WIDTH-1:1]};
          b   <= {b[0], b[VALUE_WIDTH-1:1]};
          cnt <= cnt + 1'b1;
          if (cnt == LAST_BIT) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (a_ge_b) begin
            a <= diff_ab;
          end else begin
            b <= diff_ba;
          end
          state <= S_REDUCE;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            is_coprime <= res;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/cpt_check.sv @@
// Port-level checker for the coprime pair test block, bound to the top level.
module cpt_check (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic is_coprime
);

  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else if (in_acc && !out_acc && pending != 2'd3) begin
      pending <= pending + 2'd1;
    end else if (out_acc && !in_acc && pending != 2'd0) begin
      pending <= pending - 2'd1;
    end
  end

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_coprime))
    else $error("Result transaction dropped or changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result valid after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("Result offered with no transaction outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd2)
    else $error("More than two transactions outstanding");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 |-> !in_ready)
    else $error("Input accepted with result pending and one in progress");

endmodule

bind coprime_pair_test cpt_check u_cpt_check (.*);
